### hw/rtl/blerf_pkg.sv
// Shared types, constants and the service UUID table for the advertising
// record filter. No dependencies.
package blerf_pkg;

  localparam logic [7:0]  SERVICE_TYPE = 8'h07;
  localparam logic [7:0]  MAKER_TYPE   = 8'hFF;
  localparam logic [7:0]  SERVICE_LEN  = 8'd17;
  localparam logic [7:0]  MAKER_LEN    = 8'd9;
  localparam logic [15:0] MFR_ID_RESET = 16'd919;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic service_seen;
    logic maker_seen;
    logic hub_found;
  } out_word_t;

  typedef struct packed {
    logic       expect_length;
    logic [7:0] record_length;
    logic [7:0] record_type;
    logic [7:0] byte_position;
    logic       still_matching;
    logic       service_flag;
    logic       maker_flag;
  } walk_state_t;

  localparam walk_state_t WALK_RESET = '{
    expect_length:  1'b1,
    record_length:  8'd0,
    record_type:    8'd0,
    byte_position:  8'd0,
    still_matching: 1'b0,
    service_flag:   1'b0,
    maker_flag:     1'b0
  };

  function automatic logic [7:0] service_uuid(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'h23;
      4'd1:    v = 8'hd1;
      4'd2:    v = 8'hbc;
      4'd3:    v = 8'hea;
      4'd4:    v = 8'h5f;
      4'd5:    v = 8'h78;
      4'd6:    v = 8'h23;
      4'd7:    v = 8'h16;
      4'd8:    v = 8'hde;
      4'd9:    v = 8'hef;
      4'd10:   v = 8'h12;
      4'd11:   v = 8'h12;
      4'd12:   v = 8'h23;
      4'd13:   v = 8'h16;
      4'd14:   v = 8'h00;
      4'd15:   v = 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/blerf_walker.sv
// Record walker: next-state logic for one payload byte of the LTV walk.
// Depends on blerf_pkg.
module blerf_walker import blerf_pkg::*; (
  input  walk_state_t cur,
  input  logic [7:0]  data_byte,
  input  logic [15:0] manufacturer_id,
  output walk_state_t nxt
);

  logic [7:0] k_minus_1;
  logic       type_match;
  logic       still;
  logic       rec_end;

  assign k_minus_1 = cur.byte_position - 8'd1;

  always_comb begin
    nxt        = cur;
    type_match = ((data_byte == SERVICE_TYPE) && (cur.record_length == SERVICE_LEN)) ||
                 ((data_byte == MAKER_TYPE) && (cur.record_length == MAKER_LEN));
    still      = cur.still_matching;
    rec_end    = ({1'b0, cur.byte_position} + 9'd1) >= {1'b0, cur.record_length};

    if (cur.expect_length) begin
      nxt.record_length  = data_byte;
      nxt.byte_position  = 8'd0;
      nxt.still_matching = 1'b0;
      nxt.expect_length  = (data_byte == 8'd0);
    end else begin
      if (cur.byte_position == 8'd0) begin
        nxt.record_type = data_byte;
        still           = type_match;
      end else if (cur.still_matching) begin
        if (cur.record_type == SERVICE_TYPE) begin
          if (service_uuid(k_minus_1[3:0]) != data_byte) begin
            still = 1'b0;
          end
        end else if (cur.record_type == MAKER_TYPE) begin
          if ((cur.byte_position == 8'd1) && (data_byte != manufacturer_id[7:0])) begin
            still = 1'b0;
          end
          if ((cur.byte_position == 8'd2) && (data_byte != manufacturer_id[15:8])) begin
            still = 1'b0;
          end
        end
      end

      if (rec_end) begin
        if (still) begin
          if (nxt.record_type == SERVICE_TYPE) begin
            nxt.service_flag = 1'b1;
          end else if (nxt.record_type == MAKER_TYPE) begin
            nxt.maker_flag = 1'b1;
          end
        end
        nxt.expect_length  = 1'b1;
        nxt.byte_position  = 8'd0;
        nxt.still_matching = 1'b0;
      end else begin
        nxt.byte_position  = cur.byte_position + 8'd1;
        nxt.still_matching = still;
      end
    end
  end

endmodule

### hw/rtl/ble_adv_record_filter_core.sv
// Advertising record filter top level: walk state, manufacturer ID register
// and result register. Depends on blerf_pkg and blerf_walker.
//
//  channel  signals                      word         dir
//  in       in_valid, in_ready, in_word  in_word_t    in
//  out      out_valid, out_ready, out_word out_word_t out
//  cfg      cfg_valid, cfg_ready, cfg_data 16 bits    in
//
// One byte per cycle while in_ready is high; the walk state updates in the cycle the byte is taken.
// A report's result appears in the result register in the cycle after its last
// byte is taken. in_ready drops only while a result waits and out_ready is low.
// Synchronous reset clears the walk and out_valid and sets manufacturer_id to 919.
module ble_adv_record_filter_core import blerf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  walk_state_t st;
  walk_state_t st_next;
  logic [15:0] manufacturer_id;
  logic        in_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;

  blerf_walker u_walker (
    .cur             (st),
    .data_byte       (in_word.data_byte),
    .manufacturer_id (manufacturer_id),
    .nxt             (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= WALK_RESET;
      manufacturer_id <= MFR_ID_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        manufacturer_id <= cfg_data;
      end
      out_valid <= (in_take && in_word.last_byte) || (out_valid && !out_ready);
      if (in_take) begin
        if (in_word.last_byte) begin
          st <= WALK_RESET;
        end else begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_word.last_byte) begin
      out_word.service_seen <= st_next.service_flag;
      out_word.maker_seen   <= st_next.maker_flag;
      out_word.hub_found    <= st_next.service_flag && st_next.maker_flag;
    end
  end

`ifndef SYNTHESIS
  a_hub_and: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.hub_found == (out_word.service_seen && out_word.maker_seen)))
    else $error("hub_found differs from AND of marks");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_word.last_byte) |=> out_valid)
    else $error("no result after last byte");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_word.last_byte) |=>
      (st.expect_length && !st.service_flag && !st.maker_flag))
    else $error("walk not cleared after report");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(in_valid && in_ready && in_word.last_byte)) |=> !out_valid)
    else $error("result without last byte");
`endif

endmodule
